// ----- hw/rtl/sbct_pkg.sv -----
// Shared types, widths and helper functions for the swept box collision time block.
// Used by every module of the block; depends on nothing else.
package sbct_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int CW = 32;          // coordinate and quotient width
	localparam int GW = CW + 1;      // gap width, never wraps
	localparam int TW = CW + 2;      // axis time width, room for the infinity marks
	localparam int LANES = 4;        // x entry, x exit, y entry, y exit
	localparam int AXES = 2;
	localparam int DIV_STAGES = CW;  // one quotient bit per stage

	localparam int LANE_X_IN  = 0;
	localparam int LANE_X_OUT = 1;
	localparam int LANE_Y_IN  = 2;
	localparam int LANE_Y_OUT = 3;
	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;

	localparam logic signed [TW-1:0] T_MAX  = TW'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [TW-1:0] T_MIN  = -TW'(64'sh0000_0000_8000_0000);
	localparam logic signed [TW-1:0] T_PINF = TW'(64'sh0000_0001_0000_0000);
	localparam logic signed [TW-1:0] T_NINF = -TW'(64'sh0000_0001_0000_0000);

	localparam logic [1:0] NORM_ZERO = 2'b00;
	localparam logic [1:0] NORM_POS  = 2'b01;
	localparam logic [1:0] NORM_NEG  = 2'b11;

	typedef logic signed [TW-1:0] axis_tm_t;

	typedef struct packed {
		logic [CW-1:0] rem;
		logic [CW-1:0] low;
		logic [CW-1:0] dvs;
		logic          ovf;
	} lane_t;

	typedef struct packed {
		logic neg_in;
		logic neg_out;
		logic gin_neg;
		logic vzero;
	} axis_meta_t;

	// Applies sign and saturation to an unsigned quotient; a still axis gets infinities.
	function automatic axis_tm_t sat_time(input logic [CW-1:0] q, input logic ovf,
			input logic neg, input logic vzero, input logic entry);
		axis_tm_t r;
		if (vzero) begin
			r = entry ? T_NINF : T_PINF;
		end else if (neg) begin
			if (ovf || q > 32'h8000_0000)
				r = T_MIN;
			else
				r = -$signed({2'b00, q});
		end else begin
			if (ovf || q[CW-1])
				r = T_MAX;
			else
				r = $signed({2'b00, q});
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/sbct_prep.sv -----
// Front stages: entry and exit gaps, then divider operands and overflow pre-check.
// Depends on sbct_pkg.
module sbct_prep #(
	parameter int COORD_FRAC_BITS = sbct_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [31:0] moving_left,
	input  logic [31:0] moving_top,
	input  logic [31:0] moving_right,
	input  logic [31:0] moving_bottom,
	input  logic [31:0] step_x,
	input  logic [31:0] step_y,
	input  logic [31:0] fixed_left,
	input  logic [31:0] fixed_top,
	input  logic [31:0] fixed_right,
	input  logic [31:0] fixed_bottom,
	output sbct_pkg::lane_t [sbct_pkg::LANES-1:0] lanes,
	output sbct_pkg::axis_meta_t [sbct_pkg::AXES-1:0] metas
);
	import sbct_pkg::*;

	localparam int DW = GW + COORD_FRAC_BITS;

	logic [GW-1:0] d_flmr, d_frml, d_ftmb, d_fbmt;
	logic [GW-1:0] gap_s1 [LANES];
	logic [CW-1:0] vel_s1 [AXES];
	lane_t [LANES-1:0] lane_s2;
	axis_meta_t [AXES-1:0] meta_s2;
	logic vpos_x, vpos_y;

	assign d_flmr = {fixed_left[31], fixed_left} - {moving_right[31], moving_right};
	assign d_frml = {fixed_right[31], fixed_right} - {moving_left[31], moving_left};
	assign d_ftmb = {fixed_top[31], fixed_top} - {moving_bottom[31], moving_bottom};
	assign d_fbmt = {fixed_bottom[31], fixed_bottom} - {moving_top[31], moving_top};
	assign vpos_x = !step_x[31] && (step_x != '0);
	assign vpos_y = !step_y[31] && (step_y != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			gap_s1[LANE_X_IN]  <= vpos_x ? d_flmr : d_frml;
			gap_s1[LANE_X_OUT] <= vpos_x ? d_frml : d_flmr;
			gap_s1[LANE_Y_IN]  <= vpos_y ? d_ftmb : d_fbmt;
			gap_s1[LANE_Y_OUT] <= vpos_y ? d_fbmt : d_ftmb;
			vel_s1[AXIS_X] <= step_x;
			vel_s1[AXIS_Y] <= step_y;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [GW-1:0] mag;
		logic [DW-1:0] dvd;
		logic [CW-1:0] hi, vmag, dvs;
		logic vz;

		assign mag  = gap_s1[i][GW-1] ? (GW'(0) - gap_s1[i]) : gap_s1[i];
		assign dvd  = {mag, {COORD_FRAC_BITS{1'b0}}};
		assign hi   = CW'(dvd[DW-1:CW]);
		assign vmag = vel_s1[i/2][CW-1] ? (CW'(0) - vel_s1[i/2]) : vel_s1[i/2];
		assign vz   = (vel_s1[i/2] == '0);
		// A still axis gets a dummy divisor; its quotient is replaced later.
		assign dvs  = vz ? CW'(1) : vmag;

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s2[i].ovf <= (hi >= dvs);
				lane_s2[i].rem <= (hi >= dvs) ? '0 : hi;
				lane_s2[i].low <= dvd[CW-1:0];
				lane_s2[i].dvs <= dvs;
			end
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		always_ff @(posedge clk) begin
			if (en) begin
				meta_s2[a].neg_in  <= gap_s1[2*a][GW-1] ^ vel_s1[a][CW-1];
				meta_s2[a].neg_out <= gap_s1[2*a+1][GW-1] ^ vel_s1[a][CW-1];
				meta_s2[a].gin_neg <= gap_s1[2*a][GW-1];
				meta_s2[a].vzero   <= (vel_s1[a] == '0);
			end
		end
	end

	assign lanes = lane_s2;
	assign metas = meta_s2;

endmodule

// ----- hw/rtl/sbct_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, low 32 quotient bits.
// Depends on sbct_pkg; the overflow flag for larger quotients travels alongside.
module sbct_divider (
	input  logic clk,
	input  logic en,
	input  sbct_pkg::lane_t lane_in,
	output logic [sbct_pkg::CW-1:0] quot,
	output logic ovf
);
	import sbct_pkg::*;

	logic [CW-1:0] rem_s  [DIV_STAGES];
	logic [CW-1:0] low_s  [DIV_STAGES];
	logic [CW-1:0] dvs_s  [DIV_STAGES];
	logic [CW-1:0] quot_s [DIV_STAGES];
	logic          ovf_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [CW-1:0] r_prev, l_prev, d_prev, q_prev;
		logic o_prev;
		logic [CW:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign r_prev = lane_in.rem;
			assign l_prev = lane_in.low;
			assign d_prev = lane_in.dvs;
			assign q_prev = '0;
			assign o_prev = lane_in.ovf;
		end else begin : g_next
			assign r_prev = rem_s[k-1];
			assign l_prev = low_s[k-1];
			assign d_prev = dvs_s[k-1];
			assign q_prev = quot_s[k-1];
			assign o_prev = ovf_s[k-1];
		end

		assign trial = {r_prev, l_prev[CW-1]};
		assign ge    = (trial >= {1'b0, d_prev});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? CW'(trial - {1'b0, d_prev}) : CW'(trial);
				low_s[k]  <= {l_prev[CW-2:0], 1'b0};
				dvs_s[k]  <= d_prev;
				quot_s[k] <= {q_prev[CW-2:0], ge};
				ovf_s[k]  <= o_prev;
			end
		end
	end

	assign quot = quot_s[DIV_STAGES-1];
	assign ovf  = ovf_s[DIV_STAGES-1];

endmodule

// ----- hw/rtl/swept_box_collision_time.sv -----
// Swept axis-aligned box collision time in 2D, signed fixed point, fully pipelined.
// Top level; depends on sbct_pkg, sbct_prep and sbct_divider.
//
// The block accepts one box pair per clock cycle while the pipeline advances and returns
// one result per pair, in order: the prep stages form the gaps and divider operands, the
// divider stages run four parallel restoring dividers one quotient bit per stage, a
// saturation stage saturates the axis times and a final stage resolves hit time and normal
// into the output register. The whole pipeline advances together; it holds, and takes no
// new transfer, while a result waits and out_ready is low. A miss reports hit_time 65536
// with both normals zero.
module swept_box_collision_time #(
	parameter int COORD_FRAC_BITS = sbct_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] moving_left,
	input  logic [31:0] moving_top,
	input  logic [31:0] moving_right,
	input  logic [31:0] moving_bottom,
	input  logic [31:0] step_x,
	input  logic [31:0] step_y,
	input  logic [31:0] fixed_left,
	input  logic [31:0] fixed_top,
	input  logic [31:0] fixed_right,
	input  logic [31:0] fixed_bottom,
	output logic out_valid,
	input  logic out_ready,
	output logic [16:0] hit_time,
	output logic signed [1:0] normal_horizontal,
	output logic signed [1:0] normal_vertical
);
	import sbct_pkg::*;

	localparam int LAT = 2 + DIV_STAGES + 2;
	localparam int SH_R = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
	localparam int SH_L = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;
	localparam axis_tm_t T_ONE = TW'(1) << COORD_FRAC_BITS;

	logic advance;
	logic [LAT-1:0] vld_s;
	lane_t [LANES-1:0] lanes;
	axis_meta_t [AXES-1:0] metas;
	axis_meta_t [AXES-1:0] meta_s [DIV_STAGES];
	logic [CW-1:0] quot [LANES];
	logic ovf [LANES];
	axis_tm_t tm_s35 [LANES];
	logic gin_neg_s35 [AXES];
	axis_tm_t tin, tout;
	logic miss;
	logic [TW-1:0] ht_wide;
	logic [16:0] hit_time_s36;
	logic [1:0] nh_s36, nv_s36;

	// A transfer in is taken whenever the output slot is free or being emptied.
	assign advance  = !vld_s[LAT-1] || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	sbct_prep #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_prep (
		.clk, .en(advance),
		.moving_left, .moving_top, .moving_right, .moving_bottom,
		.step_x, .step_y,
		.fixed_left, .fixed_top, .fixed_right, .fixed_bottom,
		.lanes, .metas
	);

	for (genvar i = 0; i < LANES; i++) begin : g_div
		sbct_divider u_div (
			.clk, .en(advance), .lane_in(lanes[i]), .quot(quot[i]), .ovf(ovf[i])
		);
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_meta
		always_ff @(posedge clk) begin
			if (advance)
				meta_s[k] <= (k == 0) ? metas : meta_s[(k == 0) ? 0 : k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < LANES; i++) begin
				tm_s35[i] <= sat_time(quot[i], ovf[i],
					(i % 2 == 0) ? meta_s[DIV_STAGES-1][i/2].neg_in
						: meta_s[DIV_STAGES-1][i/2].neg_out,
					meta_s[DIV_STAGES-1][i/2].vzero, (i % 2 == 0));
			end
			for (int a = 0; a < AXES; a++)
				gin_neg_s35[a] <= meta_s[DIV_STAGES-1][a].gin_neg;
		end
	end

	assign tin  = (tm_s35[LANE_X_IN] > tm_s35[LANE_Y_IN]) ? tm_s35[LANE_X_IN]
		: tm_s35[LANE_Y_IN];
	assign tout = (tm_s35[LANE_X_OUT] < tm_s35[LANE_Y_OUT]) ? tm_s35[LANE_X_OUT]
		: tm_s35[LANE_Y_OUT];
	assign miss = (tin > tout)
		|| (tm_s35[LANE_X_IN] < 0 && tm_s35[LANE_Y_IN] < 0)
		|| (tm_s35[LANE_X_IN] > T_ONE) || (tm_s35[LANE_Y_IN] > T_ONE);
	// On a hit the entry time lies in [0, one], so the rescaled value fits 17 bits.
	assign ht_wide = (TW'(tin) >> SH_R) << SH_L;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (miss) begin
				hit_time_s36 <= 17'h10000;
				nh_s36 <= NORM_ZERO;
				nv_s36 <= NORM_ZERO;
			end else if (tm_s35[LANE_X_IN] > tm_s35[LANE_Y_IN]) begin
				hit_time_s36 <= ht_wide[16:0];
				nh_s36 <= gin_neg_s35[AXIS_X] ? NORM_POS : NORM_NEG;
				nv_s36 <= NORM_ZERO;
			end else begin
				hit_time_s36 <= ht_wide[16:0];
				nh_s36 <= NORM_ZERO;
				nv_s36 <= gin_neg_s35[AXIS_Y] ? NORM_POS : NORM_NEG;
			end
		end
	end

	assign out_valid         = vld_s[LAT-1];
	assign hit_time          = hit_time_s36;
	assign normal_horizontal = nh_s36;
	assign normal_vertical   = nv_s36;

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_time <= 17'h10000)
		else $error("hit time beyond one step");
	a_one_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nh_s36 == NORM_ZERO || nv_s36 == NORM_ZERO))
		else $error("normal on both axes");
	a_norm_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nh_s36 != 2'b10 && nv_s36 != 2'b10))
		else $error("normal component out of range");
	a_miss_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nh_s36 == NORM_ZERO && nv_s36 == NORM_ZERO |-> hit_time == 17'h10000)
		else $error("hit reported without a normal");

endmodule
